[design/awit_pkg.sv]
package awit_pkg;

   localparam int ID_COUNT_DEF     = 64;
   localparam int PER_ID_DEPTH_DEF = 8;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_CHECK  = 2'd1;
   localparam logic [1:0] KIND_RESP   = 2'd2;
   localparam logic [1:0] KIND_RETIRE = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOENT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_UNDER = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  axi_id;
      logic [15:0] dest_id;
      logic [15:0] resp_count;
      logic [3:0]  chan;
      logic        slave_err;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        dest_match;
      logic        resp_ready;
      logic [15:0] ret_dest;
      logic [15:0] ret_count;
      logic [3:0]  ret_chan;
      logic        ret_error;
      logic [9:0]  outstanding;
   } rsp_type;

   typedef struct packed {
      logic [15:0] dest;
      logic [15:0] count;
      logic [3:0]  chan;
      logic        err;
   } entry_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic load;
      logic ent_rd;
      logic commit;
   } cmd_type;

endpackage

[design/awit_ctrl.sv]
module awit_ctrl
   import awit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RD_ID  = 2'd1;
   localparam logic [1:0] ST_RD_ENT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.ent_rd = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RD_ID;
            end
         end
         ST_RD_ID: begin
            cmd.ent_rd = 1'b1;
            state_in   = ST_RD_ENT;
         end
         ST_RD_ENT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/awit_dp.sv]
module awit_dp
   import awit_pkg::*;
#(
   parameter int ID_COUNT     = ID_COUNT_DEF,
   parameter int PER_ID_DEPTH = PER_ID_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int IXW   = $clog2(ID_COUNT);
   localparam int SW    = (PER_ID_DEPTH > 1) ? $clog2(PER_ID_DEPTH) : 1;
   localparam int FW    = $clog2(PER_ID_DEPTH + 1);
   localparam int ENT_N = ID_COUNT * PER_ID_DEPTH;
   localparam int AW    = (ENT_N > 1) ? $clog2(ENT_N) : 1;
   localparam int TW    = $clog2(ENT_N + 1);

   entry_type ent_mem [ENT_N];
   logic [SW-1:0] idt_head_mem [ID_COUNT];
   logic [FW-1:0] idt_fill_mem [ID_COUNT];

   logic [ID_COUNT-1:0] vld_ff;
   logic [TW-1:0]       total_ff;
   logic [TW-1:0]       total_in;
   req_type             req_ff;
   logic                valid_id_ff;
   logic [IXW-1:0]      idx_ff;
   logic                vld_rd_ff;
   logic [SW-1:0]       head_rd_ff;
   logic [FW-1:0]       fill_rd_ff;
   entry_type           ent_rd_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic           valid_id;
   logic [IXW-1:0] idx;
   logic [SW-1:0]  head_cur;
   logic [FW-1:0]  fill_cur;
   logic [AW-1:0]  base_addr;
   logic [AW-1:0]  head_addr;
   logic [SW:0]    tail_sum;
   logic [SW-1:0]  tail_slot;
   logic [SW-1:0]  head_next;
   logic           has_head;

   logic           ent_we;
   logic [AW-1:0]  ent_wa;
   entry_type      ent_wd;
   logic           idt_we;
   logic [SW-1:0]  idt_head_wd;
   logic [FW-1:0]  idt_fill_wd;

   assign valid_id = (32'(req_item.axi_id) < 32'(ID_COUNT));
   assign idx      = valid_id ? IXW'(req_item.axi_id) : '0;

   // never-written ids read as an empty queue
   assign head_cur  = vld_rd_ff ? head_rd_ff : '0;
   assign fill_cur  = vld_rd_ff ? fill_rd_ff : '0;
   assign has_head  = valid_id_ff && (fill_cur != '0);
   assign base_addr = AW'(idx_ff) * AW'(PER_ID_DEPTH);
   assign head_addr = base_addr + AW'(head_cur);

   // head is below the depth and fill at most the depth, so one subtract wraps
   assign tail_sum  = {1'b0, head_cur} + (SW + 1)'(fill_cur);
   assign tail_slot = (tail_sum >= (SW + 1)'(PER_ID_DEPTH))
                      ? SW'(tail_sum - (SW + 1)'(PER_ID_DEPTH)) : SW'(tail_sum);
   assign head_next = (head_cur == SW'(PER_ID_DEPTH - 1)) ? '0 : head_cur + SW'(1);

   always_comb begin
      ent_we      = 1'b0;
      ent_wa      = head_addr;
      ent_wd      = ent_rd_ff;
      idt_we      = 1'b0;
      idt_head_wd = head_cur;
      idt_fill_wd = fill_cur;
      total_in    = total_ff;
      rsp_in      = '0;
      rsp_in.status = STATUS_OK;
      case (req_ff.kind)
         KIND_ADD: begin
            if (!valid_id_ff || (32'(fill_cur) >= 32'(PER_ID_DEPTH))) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               ent_we      = cmd.commit;
               ent_wa      = base_addr + AW'(tail_slot);
               ent_wd.dest = req_ff.dest_id;
               ent_wd.count = req_ff.resp_count;
               ent_wd.chan = req_ff.chan;
               ent_wd.err  = 1'b0;
               idt_we      = cmd.commit;
               idt_fill_wd = fill_cur + FW'(1);
               total_in    = total_ff + TW'(1);
            end
         end
         KIND_CHECK: begin
            rsp_in.dest_match = !has_head || (ent_rd_ff.dest == req_ff.dest_id);
         end
         KIND_RESP: begin
            if (!has_head) begin
               rsp_in.status = STATUS_NOENT;
            end else if (ent_rd_ff.count == '0) begin
               rsp_in.status = STATUS_UNDER;
            end else begin
               ent_we       = cmd.commit;
               ent_wd.count = ent_rd_ff.count - 16'd1;
               ent_wd.err   = ent_rd_ff.err | req_ff.slave_err;
               rsp_in.resp_ready = (ent_rd_ff.count == 16'd1);
            end
         end
         KIND_RETIRE: begin
            if (!has_head) begin
               rsp_in.status = STATUS_NOENT;
            end else begin
               rsp_in.ret_dest  = ent_rd_ff.dest;
               rsp_in.ret_count = ent_rd_ff.count;
               rsp_in.ret_chan  = ent_rd_ff.chan;
               rsp_in.ret_error = ent_rd_ff.err;
               idt_we      = cmd.commit;
               idt_head_wd = head_next;
               idt_fill_wd = fill_cur - FW'(1);
               total_in    = total_ff - TW'(1);
            end
         end
         default: begin
            rsp_in.status = STATUS_NOENT;
         end
      endcase
      rsp_in.outstanding = 10'(total_in);
   end

   // per-id table of head slot and fill count (its valid bits are in the reset block)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         head_rd_ff <= idt_head_mem[idx];
         fill_rd_ff <= idt_fill_mem[idx];
      end
      if (idt_we) begin
         idt_head_mem[idx_ff] <= idt_head_wd;
         idt_fill_mem[idx_ff] <= idt_fill_wd;
      end
   end

   // entry store
   always_ff @(posedge clock) begin
      if (cmd.ent_rd) begin
         ent_rd_ff <= ent_mem[head_addr];
      end
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_item;
         valid_id_ff <= valid_id;
         idx_ff      <= idx;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         vld_rd_ff    <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            vld_rd_ff <= valid_id && vld_ff[idx];
         end
         if (idt_we) begin
            vld_ff[idx_ff] <= 1'b1;
         end
         if (cmd.commit) begin
            total_ff <= total_in;
         end
         rsp_valid_ff <= cmd.commit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[design/axi_write_id_tracker_core.sv]
// each accepted item passes an id table read, an entry read and a write-back
// before its result is strobed; no new item is taken while busy
// the next item is taken in the cycle the previous result is strobed
// results cannot be stalled; rsp_valid lasts exactly one cycle
// reset: synchronous, clears all queues, valid bits and the outstanding count
module axi_write_id_tracker_core
   import awit_pkg::*;
#(
   parameter int ID_COUNT     = ID_COUNT_DEF,
   parameter int PER_ID_DEPTH = PER_ID_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type cmd;

   awit_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   awit_dp #(
      .ID_COUNT     (ID_COUNT),
      .PER_ID_DEPTH (PER_ID_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while an item is still in work");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted item produced no result");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("tracker did not go busy after accepting an item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.dest_match == 1'b0 || rsp_item.status == STATUS_OK))
      else $error("destination match reported with a failing status");

endmodule
